>>> hdl/lfsreg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lowest-free-slot registry.
// Used by lfsreg_ctrl, lfsreg_dp and lowest_free_slot_registry_top.

package lfsreg_pkg;

    localparam int DEF_NUM_SLOTS = 8;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 16;
    localparam int ID_W     = 3;
    localparam int STATUS_W = 2;

    // stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_ID  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_KEY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_RUN,
        CTL_TAIL
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic advance;
        logic emit;
        logic tail_emit;
        logic flush;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic chk_vld;
        logic chk_stop;
        logic chk_emit;
        logic issue_left;
        logic out_busy;
    } dp_sts_t;

endpackage

>>> hdl/lowest_free_slot_registry_top.sv
`timescale 1ns / 1ps
// Lowest-free-slot registry: remove, find by id and unknown codes check a single
// slot and give one result beat; add, find by key and list walk the slots one per
// cycle through the key memory read port, stalling only while a result waits on a
// full output register, and list gives one beat per live slot, or one miss beat if none.
// A new command is taken once the previous one has issued its last beat.
// Reset clears every live bit; stored keys are undefined until written.

module lowest_free_slot_registry_top
    import lfsreg_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // conn_key[15:0], slot_id[18:16]
    input  logic [CMD_W-1:0]     s_tuser,   // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_slot[2:0], out_key[18:3]
    output logic [STATUS_W-1:0]  m_tuser,   // status[1:0]
    output logic                 m_tlast
);

    dp_cmd_t          ctl;
    dp_sts_t          sts;
    logic [ID_W-1:0]  out_slot;
    logic [KEY_W-1:0] out_key;

    lfsreg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    lfsreg_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_id      (s_tdata[KEY_W+ID_W-1:KEY_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_key    (out_key),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - KEY_W - ID_W){1'b0}}, out_key, out_slot};

endmodule

>>> hdl/lfsreg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the slot registry: accepts a command beat, steps the slot scan
// and decides when a result is written out. Depends on lfsreg_pkg.

module lfsreg_ctrl
    import lfsreg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t ctl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       adv;

    // stall the scan only while a result is waiting on a full output register
    assign adv = !(sts.chk_vld && sts.chk_emit && sts.out_busy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = CTL_RUN;
                end
            end
            CTL_RUN:
            begin
                priority if (adv && sts.chk_vld && sts.chk_stop)
                begin
                    state_next = CTL_IDLE;
                end
                else if (adv && sts.chk_vld && !sts.issue_left)
                begin
                    state_next = CTL_TAIL;
                end
            end
            CTL_TAIL:
            begin
                if (!sts.out_busy)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                s_tready    = 1'b1;
                ctl.capture = s_tvalid;
            end
            CTL_RUN:
            begin
                ctl.advance = adv;
                ctl.issue   = adv && sts.issue_left;
                ctl.emit    = adv && sts.chk_vld && sts.chk_emit;
                ctl.flush   = adv && sts.chk_vld && sts.chk_stop;
            end
            CTL_TAIL:
            begin
                ctl.tail_emit = !sts.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/lfsreg_dp.sv
`timescale 1ns / 1ps
// Datapath of the slot registry: live bits, key memory with registered read,
// scan counter, slot check stage and output register. Depends on lfsreg_pkg.

module lfsreg_dp
    import lfsreg_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             ctl,
    output dp_sts_t             sts,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [ID_W-1:0]     in_id,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [ID_W-1:0]     out_slot,
    output logic [KEY_W-1:0]    out_key,
    output logic                out_last
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = ((IW > ID_W) ? IW : ID_W) + 1;

    // captured command
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ID_W-1:0]     id_reg;

    // scan
    logic [IW-1:0]       idx_reg;
    logic                issue_left_reg;

    // check stage
    logic                chk_vld_reg;
    logic [IW-1:0]       chk_idx_reg;
    logic                chk_live_reg;
    logic [KEY_W-1:0]    chk_key_reg;

    // table
    logic [NUM_SLOTS-1:0] live_reg;
    logic [KEY_W-1:0]     key_mem [NUM_SLOTS];

    // output register
    logic                out_vld_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_slot_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic                out_last_reg;

    logic                single;
    logic                id_ok;
    logic [IW-1:0]       rd_addr;
    logic                rd_ok;
    logic                last_idx;
    logic                live_above;

    logic                stop;
    logic                em;
    logic [STATUS_W-1:0] res_status;
    logic [ID_W-1:0]     res_slot;
    logic [KEY_W-1:0]    res_key;
    logic                res_last;
    logic [STATUS_W-1:0] tail_status;
    logic [KEY_W-1:0]    tail_key;

    // remove, find by id and unknown codes touch one slot only
    assign single = !(cmd_reg == CMD_ADD || cmd_reg == CMD_FIND_KEY || cmd_reg == CMD_LIST);
    assign id_ok    = CW'(id_reg) < CW'(NUM_SLOTS);
    assign rd_addr  = single ? (id_ok ? IW'(id_reg) : '0) : idx_reg;
    assign rd_ok    = single ? id_ok : 1'b1;
    assign last_idx = (idx_reg == IW'(NUM_SLOTS - 1));
    assign live_above = |((live_reg >> chk_idx_reg) >> 1);

    always_comb
    begin
        stop       = 1'b1;
        em         = 1'b1;
        res_status = ST_MISS;
        res_slot   = '0;
        res_key    = '0;
        res_last   = 1'b1;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                stop       = !chk_live_reg;
                em         = !chk_live_reg;
                res_status = ST_OK;
                res_slot   = ID_W'(chk_idx_reg);
                res_key    = key_reg;
            end
            CMD_REMOVE, CMD_FIND_ID:
            begin
                res_status = chk_live_reg ? ST_OK : ST_MISS;
                res_slot   = id_reg;
                res_key    = chk_live_reg ? chk_key_reg : '0;
            end
            CMD_FIND_KEY:
            begin
                stop       = chk_live_reg && (chk_key_reg == key_reg);
                em         = chk_live_reg && (chk_key_reg == key_reg);
                res_status = ST_OK;
                res_slot   = ID_W'(chk_idx_reg);
                res_key    = key_reg;
            end
            CMD_LIST:
            begin
                // the highest live slot closes the list
                stop       = chk_live_reg && !live_above;
                em         = chk_live_reg;
                res_status = ST_OK;
                res_slot   = ID_W'(chk_idx_reg);
                res_key    = chk_key_reg;
                res_last   = !live_above;
            end
            default:
            begin
                res_status = ST_MISS;
            end
        endcase
    end

    // result after a scan that found nothing
    always_comb
    begin
        tail_status = ST_MISS;
        tail_key    = '0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                tail_status = ST_FULL;
            end
            CMD_FIND_KEY:
            begin
                tail_key = key_reg;
            end
            default:
            begin
                tail_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            issue_left_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            live_reg       <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                idx_reg        <= '0;
                issue_left_reg <= 1'b1;
            end
            else if (ctl.issue)
            begin
                if (single || last_idx)
                begin
                    issue_left_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (ctl.advance)
            begin
                chk_vld_reg <= ctl.issue && !ctl.flush;
            end

            if (ctl.emit)
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    live_reg[chk_idx_reg] <= 1'b1;
                end
                else if (cmd_reg == CMD_REMOVE && chk_live_reg)
                begin
                    live_reg[chk_idx_reg] <= 1'b0;
                end
            end

            if (ctl.emit || ctl.tail_emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.emit && cmd_reg == CMD_ADD)
        begin
            key_mem[chk_idx_reg] <= key_reg;
        end
        if (ctl.issue)
        begin
            chk_key_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            id_reg  <= in_id;
        end
        if (ctl.issue)
        begin
            chk_idx_reg  <= rd_addr;
            chk_live_reg <= rd_ok && live_reg[rd_addr];
        end
        if (ctl.emit)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_key_reg    <= res_key;
            out_last_reg   <= res_last;
        end
        else if (ctl.tail_emit)
        begin
            out_status_reg <= tail_status;
            out_slot_reg   <= '0;
            out_key_reg    <= tail_key;
            out_last_reg   <= 1'b1;
        end
    end

    assign sts.chk_vld    = chk_vld_reg;
    assign sts.chk_stop   = stop;
    assign sts.chk_emit   = em;
    assign sts.issue_left = issue_left_reg;
    assign sts.out_busy   = out_vld_reg && !out_ready;

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_key    = out_key_reg;
    assign out_last   = out_last_reg;

endmodule

>>> tb/sv/lowest_free_slot_registry_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lowest_free_slot_registry_top: mirrors the slot table,
// predicts every reply beat and compares it field by field under random stalls.
// Depends on lfsreg_pkg and the top level only.

module lowest_free_slot_registry_top_tb;
    import lfsreg_pkg::*;

    localparam int NSLOT           = DEF_NUM_SLOTS;
    localparam int RANDOM_CMDS     = 425;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 150;
    localparam int DRAIN_CYCLES    = 2 * NSLOT + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     slot;
        logic [KEY_W-1:0]    key;
        logic                last;
    } reply_t;

    class slot_registry_sb;
        bit               live [NSLOT];
        logic [KEY_W-1:0] held_key [NSLOT];
        reply_t           replies [$];
        int errors;
        int n_cmds;
        int n_beats;
        int n_full;
        int n_lists;
        int peak_live;

        function new();
            foreach (live[i])
            begin
                live[i]     = 1'b0;
                held_key[i] = '0;
            end
        endfunction

        function int live_count();
            int cnt;
            cnt = 0;
            foreach (live[i])
                if (live[i])
                    cnt++;
            return cnt;
        endfunction

        // random live slot, -1 when the table is empty
        function int random_live_slot();
            int picks [$];
            foreach (live[i])
                if (live[i])
                    picks = {picks, i};
            if (picks.size() == 0)
                return -1;
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void push(logic [STATUS_W-1:0] status, int slot, logic [KEY_W-1:0] key,
                           logic last);
            reply_t r;
            r.status = status;
            r.slot   = ID_W'(slot);
            r.key    = key;
            r.last   = last;
            replies  = {replies, r};
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [ID_W-1:0] id);
            int hit;
            int last_i;
            hit    = -1;
            last_i = -1;
            n_cmds++;
            case (cmd)
                CMD_ADD:
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!live[i] && hit < 0)
                            hit = i;
                    if (hit >= 0)
                    begin
                        live[hit]     = 1'b1;
                        held_key[hit] = key;
                        push(ST_OK, hit, key, 1'b1);
                    end
                    else
                    begin
                        n_full++;
                        push(ST_FULL, 0, '0, 1'b1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (int'(id) < NSLOT && live[id])
                    begin
                        live[id] = 1'b0;
                        push(ST_OK, id, held_key[id], 1'b1);
                    end
                    else
                        push(ST_MISS, id, '0, 1'b1);
                end
                CMD_FIND_ID:
                begin
                    if (int'(id) < NSLOT && live[id])
                        push(ST_OK, id, held_key[id], 1'b1);
                    else
                        push(ST_MISS, id, '0, 1'b1);
                end
                CMD_FIND_KEY:
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (live[i] && held_key[i] == key && hit < 0)
                            hit = i;
                    if (hit >= 0)
                        push(ST_OK, hit, key, 1'b1);
                    else
                        push(ST_MISS, 0, key, 1'b1);
                end
                CMD_LIST:
                begin
                    n_lists++;
                    for (int i = 0; i < NSLOT; i++)
                        if (live[i])
                            last_i = i;
                    if (last_i < 0)
                        push(ST_MISS, 0, '0, 1'b1);
                    for (int i = 0; i < NSLOT; i++)
                        if (live[i])
                            push(ST_OK, i, held_key[i], i == last_i);
                end
                default:
                    push(ST_MISS, 0, '0, 1'b1);
            endcase
            if (live_count() > peak_live)
                peak_live = live_count();
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            n_beats++;
            if (replies.size() == 0)
            begin
                $display("%0t: unexpected reply beat, got status %0d slot %0d key %h last %0d",
                         $time, got.status, got.slot, got.key, got.last);
                errors++;
                return;
            end
            want = replies.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $display("%0t: out_slot mismatch, expected %0d, got %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
            if (got.key !== want.key)
            begin
                $display("%0t: out_key mismatch, expected %h, got %h",
                         $time, want.key, got.key);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: tlast mismatch, expected %0d, got %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    slot_registry_sb sb;
    bit              burst_mode;
    bit              hold_done;
    int              idle_cycles;

    lowest_free_slot_registry_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one; none during a burst stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = sb.random_live_slot();
        if (r < 30)
        begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h8000;
                3: return 16'h0001;
                4: return 16'h5A5A;
                default: return 16'hA5A5;
            endcase
        end
        if (r < 60 && s >= 0)
            return sb.held_key[s];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_slot();
        int s;
        s = sb.random_live_slot();
        if ($urandom_range(0, 99) < 70 && s >= 0)
            return ID_W'(s);
        return ID_W'($urandom_range(0, 2 ** ID_W - 1));
    endfunction

    // hold valid across back-to-back beats; drop it only for a real gap
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                logic [ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - KEY_W - ID_W){1'b0}}, id, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // receiver: random ready runs and stalls, one long hold-off to back the block up
    initial
    begin
        int run;
        int gap;
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge clk);
            if (!hold_done && sb.n_cmds >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                gap       = HOLD_OFF_CYCLES;
            end
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.slot   = m_tdata[ID_W-1:0];
                got.key    = m_tdata[ID_W +: KEY_W];
                got.last   = m_tlast;
                sb.check_reply(got);
            end
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W +: ID_W]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles, %0d replies outstanding",
                         $time, idle_cycles, sb.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        int               r;
        int               add_pct;
        int               rem_pct;
        sb          = new();
        burst_mode  = 1'b0;
        hold_done   = 1'b0;
        idle_cycles = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ADD;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table corner cases
        send_command(CMD_LIST, 16'h0000, 3'd0);
        send_command(CMD_FIND_KEY, 16'h0000, 3'd0);
        send_command(CMD_FIND_ID, 16'h0000, 3'd7);
        send_command(CMD_REMOVE, 16'hFFFF, 3'd0);
        // fill every slot, with a duplicate key in slots 1 and 6
        send_command(CMD_ADD, 16'h0000, 3'd7);
        send_command(CMD_ADD, 16'hFFFF, 3'd0);
        send_command(CMD_ADD, 16'h8001, 3'd5);
        send_command(CMD_ADD, 16'h7FFE, 3'd2);
        send_command(CMD_ADD, 16'h5A5A, 3'd0);
        send_command(CMD_ADD, 16'hA5A5, 3'd7);
        send_command(CMD_ADD, 16'hFFFF, 3'd3);
        send_command(CMD_ADD, 16'h0001, 3'd4);
        send_command(CMD_ADD, 16'h1234, 3'd1);
        send_command(CMD_LIST, 16'h0000, 3'd0);
        send_command(CMD_FIND_KEY, 16'hFFFF, 3'd0);
        send_command(CMD_FIND_ID, 16'h0000, 3'd7);
        send_command(CMD_REMOVE, 16'h0000, 3'd1);
        send_command(CMD_FIND_KEY, 16'hFFFF, 3'd0);
        send_command(CMD_REMOVE, 16'h0000, 3'd1);
        send_command(CMD_ADD, 16'h4321, 3'd6);
        for (int u = 1; u <= 3; u++)
            send_command(CMD_LIST + CMD_W'(u), 16'hFFFF, 3'd7);
        send_command(CMD_FIND_KEY, 16'hBEEF, 3'd0);
        send_command(CMD_LIST, 16'h0000, 3'd0);

        // random traffic, alternating between filling and draining the table
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            burst_mode = (n >= 300 && n < 340);
            add_pct    = ((n / 50) % 2 == 0) ? 45 : 15;
            rem_pct    = 60 - add_pct;
            r          = $urandom_range(0, 99);
            if (r < add_pct)
                cmd = CMD_ADD;
            else if (r < add_pct + rem_pct)
                cmd = CMD_REMOVE;
            else if (r < 75)
                cmd = CMD_FIND_ID;
            else if (r < 87)
                cmd = CMD_FIND_KEY;
            else if (r < 96)
                cmd = CMD_LIST;
            else
                cmd = CMD_LIST + CMD_W'($urandom_range(1, 3));
            key = (cmd == CMD_ADD || cmd == CMD_FIND_KEY) ? pick_key() : KEY_W'($urandom);
            id  = (cmd == CMD_REMOVE || cmd == CMD_FIND_ID) ? pick_slot()
                                                              : ID_W'($urandom);
            send_command(cmd, key, id);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d lists, %0d adds rejected as full, peak %0d live",
                 sb.n_cmds, sb.n_lists, sb.n_full, sb.peak_live);
        $display("Checked %0d reply beats, %0d mismatches", sb.n_beats, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/lfsreg_pkg.sv
hdl/lfsreg_ctrl.sv
hdl/lfsreg_dp.sv
hdl/lowest_free_slot_registry_top.sv
tb/sv/lowest_free_slot_registry_top_tb.sv
